// ===== src/smr90_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smr90_pkg
// Shared constants for the square matrix quarter-turn core.
// ----------------------------------------------------------------------------
package smr90_pkg;

    localparam int MATRIX_SIZE_W = 4;
    localparam logic [MATRIX_SIZE_W-1:0] MATRIX_SIZE_RESET = 4'd8;

    localparam int DEF_MAX_SIDE   = 8;
    localparam int DEF_DATA_WIDTH = 32;

endpackage

// ===== src/smr90_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smr90_mem
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module smr90_mem #(
    parameter int DEPTH      = smr90_pkg::DEF_MAX_SIDE * smr90_pkg::DEF_MAX_SIDE,
    parameter int DATA_WIDTH = smr90_pkg::DEF_DATA_WIDTH,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/square_matrix_rotate_90_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_matrix_rotate_90_core
// Loads an n-by-n matrix one element per start, row-major, then streams it
// out turned 90 degrees clockwise, row-major, last element flagged.
// ----------------------------------------------------------------------------
// Timing: elements are taken one per cycle while busy is low. The transfer
// that completes a matrix (element n*n-1) raises busy until the last element
// has been read from the store, which is read once per cycle through its
// single read port; each result leaves on o_valid in the cycle after its
// read. Loading and emitting do not overlap. The receiver cannot stall:
// every strobed result must be taken in its cycle. A matrix_size write
// drops a partial load; writes are taken only while busy is low.
module square_matrix_rotate_90_core #(
    parameter int MAX_SIDE   = smr90_pkg::DEF_MAX_SIDE,
    parameter int DATA_WIDTH = smr90_pkg::DEF_DATA_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic signed [DATA_WIDTH-1:0]          i_element_value,
    output logic                                  o_valid,
    output logic signed [DATA_WIDTH-1:0]          o_rotated_value,
    output logic                                  o_last_of_matrix,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [smr90_pkg::MATRIX_SIZE_W-1:0]   i_cfg_data
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int MW    = smr90_pkg::MATRIX_SIZE_W;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    t_state          r_state;
    logic [MW-1:0]   r_matrix_size;
    logic [CW-1:0]   r_load_count;
    logic [SW-1:0]   r_row;
    logic [SW-1:0]   r_col;
    logic [AW-1:0]   r_src;
    logic            r_out_valid;
    logic            r_out_last;

    logic [SW-1:0]   side;
    logic [CW-1:0]   total;
    logic [CW-1:0]   top_base;
    logic [SW-1:0]   side_last;
    logic            load_xfer;
    logic            cfg_xfer;
    logic            emit_rd;
    logic            emit_last;
    logic [DATA_WIDTH-1:0] rd_data;

    // clamp side to 1..MAX_SIDE
    always_comb begin
        if (r_matrix_size == '0) begin
            side = SW'(1);
        end else if (r_matrix_size > MW'(MAX_SIDE)) begin
            side = SW'(MAX_SIDE);
        end else begin
            side = SW'(r_matrix_size);
        end
    end

    assign total     = CW'(side) * CW'(side);
    assign top_base  = total - CW'(side);
    assign side_last = side - SW'(1);

    assign load_xfer = i_start && (r_state == ST_LOAD);
    assign cfg_xfer  = i_cfg_valid && o_cfg_ready;
    assign emit_rd   = (r_state == ST_EMIT);
    assign emit_last = (r_row == side_last) && (r_col == side_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_LOAD;
            r_matrix_size <= smr90_pkg::MATRIX_SIZE_RESET;
            r_load_count  <= '0;
            r_row         <= '0;
            r_col         <= '0;
            r_src         <= '0;
            r_out_valid   <= 1'b0;
            r_out_last    <= 1'b0;
        end else begin
            r_out_valid <= emit_rd;
            r_out_last  <= emit_rd && emit_last;
            unique case (r_state)
                ST_LOAD: begin
                    if (cfg_xfer) begin
                        r_matrix_size <= i_cfg_data;
                        r_load_count  <= '0;
                    end else if (load_xfer) begin
                        if (r_load_count + CW'(1) == total) begin
                            r_load_count <= '0;
                            r_row        <= '0;
                            r_col        <= '0;
                            r_src        <= AW'(top_base);
                            r_state      <= ST_EMIT;
                        end else begin
                            r_load_count <= r_load_count + CW'(1);
                        end
                    end
                end
                ST_EMIT: begin
                    if (emit_last) begin
                        r_state <= ST_LOAD;
                    end else if (r_col == side_last) begin
                        r_col <= '0;
                        r_row <= r_row + SW'(1);
                        r_src <= AW'(top_base + CW'(r_row) + CW'(1));
                    end else begin
                        r_col <= r_col + SW'(1);
                        r_src <= r_src - AW'(side);
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    smr90_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (load_xfer && !cfg_xfer),
        .i_wr_addr (AW'(r_load_count)),
        .i_wr_data (i_element_value),
        .i_rd_en   (emit_rd),
        .i_rd_addr (r_src),
        .o_rd_data (rd_data)
    );

    assign o_busy           = (r_state == ST_EMIT);
    assign o_cfg_ready      = (r_state == ST_LOAD) && !i_start;
    assign o_valid          = r_out_valid;
    assign o_rotated_value  = rd_data;
    assign o_last_of_matrix = r_out_last;

endmodule

// ===== tb/sv/rotate_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_checker
// Watches the element, result and size channels of the quarter-turn core,
// keeps its own copy of the matrix store, the load count and the side length,
// predicts the rotated stream of each completed matrix and compares every
// strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module rotate_checker #(
    parameter int MAX_SIDE   = smr90_pkg::DEF_MAX_SIDE,
    parameter int DATA_WIDTH = smr90_pkg::DEF_DATA_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_busy,
    input  logic signed [DATA_WIDTH-1:0]          i_element_value,
    input  logic                                  i_valid,
    input  logic signed [DATA_WIDTH-1:0]          i_rotated_value,
    input  logic                                  i_last_of_matrix,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [smr90_pkg::MATRIX_SIZE_W-1:0]   i_cfg_data,
    output int                                    o_failures,
    output int                                    o_pending
);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
    } t_rotated;

    logic [smr90_pkg::MATRIX_SIZE_W-1:0] side_code;
    logic signed [DATA_WIDTH-1:0] element_mem [MAX_SIDE*MAX_SIDE];
    int unsigned                  fill_count;
    t_rotated                     rotated_q [$];
    int                           mismatches;

    initial begin
        o_failures = 0;
        o_pending  = 0;
        mismatches = 0;
        side_code  = smr90_pkg::MATRIX_SIZE_RESET;
        fill_count = 0;
    end

    always @(posedge i_clk) begin
        int unsigned side;
        int unsigned area;
        t_rotated    want;
        if (!i_rst_n) begin
            side_code  = smr90_pkg::MATRIX_SIZE_RESET;
            fill_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                side_code  = i_cfg_data;
                fill_count = 0;
            end
            // results are checked before this edge's element can add predictions
            if (i_valid) begin
                if (rotated_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: value %0d last %0b",
                                 i_rotated_value, i_last_of_matrix);
                    mismatches++;
                end else begin
                    want = rotated_q.pop_front();
                    if (i_rotated_value !== want.value || i_last_of_matrix !== want.last) begin
                        if (mismatches < 10)
                            $display({"mismatch: expected value %0d last %0b, ",
                                      "got value %0d last %0b"},
                                     want.value, want.last, i_rotated_value, i_last_of_matrix);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                side = (side_code == 0) ? 1 : ((side_code > MAX_SIDE) ? MAX_SIDE : side_code);
                area = side * side;
                if (fill_count >= area)
                    fill_count = 0;
                element_mem[fill_count] = i_element_value;
                fill_count++;
                if (fill_count == area) begin
                    fill_count = 0;
                    for (int unsigned r = 0; r < side; r++) begin
                        for (int unsigned c = 0; c < side; c++) begin
                            want.value = element_mem[(side - 1 - c) * side + r];
                            want.last  = (r * side + c == area - 1);
                            rotated_q.insert(rotated_q.size(), want);
                        end
                    end
                end
            end
        end
        o_failures <= mismatches;
        o_pending  <= rotated_q.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the quarter-turn core with directed matrices at the value extremes,
// a side length of zero and an abandoned load, then with random side
// changes, full matrices of random content and broken partial loads, with
// random gaps on the element and size channels. The checker does the
// prediction and comparison; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_SIDE     = smr90_pkg::DEF_MAX_SIDE;
    localparam int DATA_WIDTH   = smr90_pkg::DEF_DATA_WIDTH;
    localparam int MSW          = smr90_pkg::MATRIX_SIZE_W;
    localparam int ITEM_TARGET  = 480;
    localparam int CYCLE_LIMIT  = 200000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_start;
    logic                         o_busy;
    logic signed [DATA_WIDTH-1:0] i_element_value;
    logic                         o_valid;
    logic signed [DATA_WIDTH-1:0] o_rotated_value;
    logic                         o_last_of_matrix;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [MSW-1:0]               i_cfg_data;

    int failures;
    int pending;
    int cycles;
    int sent;
    bit calm;

    square_matrix_rotate_90_core #(
        .MAX_SIDE  (MAX_SIDE),
        .DATA_WIDTH(DATA_WIDTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_element_value (i_element_value),
        .o_valid         (o_valid),
        .o_rotated_value (o_rotated_value),
        .o_last_of_matrix(o_last_of_matrix),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    rotate_checker #(
        .MAX_SIDE  (MAX_SIDE),
        .DATA_WIDTH(DATA_WIDTH)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_element_value (i_element_value),
        .i_valid         (o_valid),
        .i_rotated_value (o_rotated_value),
        .i_last_of_matrix(o_last_of_matrix),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_failures      (failures),
        .o_pending       (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one element transfer, called at a falling edge and returning at one
    task automatic send_element(input logic signed [DATA_WIDTH-1:0] value);
        if (!calm && $urandom_range(99) < 9) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_start         = 1'b1;
        i_element_value = value;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
        sent++;
    endtask

    // size write once every prediction has drained and the core has settled
    task automatic write_side(input logic [MSW-1:0] code);
        i_start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if ($urandom_range(99) < 9)
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = code;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int unsigned side;
        int unsigned area;
        int unsigned code;
        int unsigned pick;
        int unsigned rounds;
        logic signed [DATA_WIDTH-1:0] value;

        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_element_value = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        sent            = 0;
        calm            = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // single-element matrices at the value extremes
        write_side(4'd1);
        send_element(32'sh7FFF_FFFF);
        send_element(32'sh8000_0000);
        send_element(32'sh0000_0000);
        send_element(32'shFFFF_FFFF);
        // side of zero behaves as side one
        write_side(4'd0);
        send_element(32'sh5555_5555);
        send_element(32'shAAAA_AAAA);
        write_side(4'd2);
        send_element(32'sh0000_0001);
        send_element(32'sh7FFF_FFFF);
        send_element(32'shAAAA_AAAA);
        send_element(32'sh8000_0000);
        // abandoned load: a size write drops the partial matrix
        write_side(4'd3);
        send_element(32'sh1111_1111);
        send_element(32'sh2222_2222);
        send_element(32'sh3333_3333);
        write_side(4'd2);
        send_element(-32'sd5);
        send_element(32'sh5555_5555);
        send_element(32'sh0F0F_F0F0);
        send_element(32'sh8000_0001);

        while (sent < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 8)       code = 0;
            else if (pick < 18) code = 1;
            else if (pick < 68) code = $urandom_range(2, 4);
            else if (pick < 84) code = $urandom_range(5, 7);
            else if (pick < 93) code = 8;
            else                code = $urandom_range(9, 15);
            write_side(code[MSW-1:0]);
            side   = (code == 0) ? 1 : ((code > MAX_SIDE) ? MAX_SIDE : code);
            area   = side * side;
            rounds = (area > 16) ? 1 : $urandom_range(1, 3);
            for (int unsigned m = 0; m <= rounds; m++) begin
                // the extra round is a broken load, cut short before the last element
                if (m == rounds && (area == 1 || $urandom_range(99) >= 15))
                    break;
                for (int unsigned e = 0; e < ((m == rounds) ? $urandom_range(1, area - 1) : area);
                     e++) begin
                    calm = (sent >= 150 && sent < 300);
                    pick = $urandom_range(99);
                    if (pick < 10)      value = 32'sh7FFF_FFFF;
                    else if (pick < 20) value = 32'sh8000_0000;
                    else if (pick < 30) value = $signed($urandom_range(0, 15)) - 8;
                    else                value = $urandom;
                    send_element(value);
                end
            end
        end

        i_start = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (MAX_SIDE * MAX_SIDE + 8) @(posedge i_clk);
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
